// ===== sv/afc_pkg.sv =====
// Package for the alive-counter / CRC-8 frame protection block.
// Holds shared constants, state and control types and the CRC byte step.
// No dependencies.
`timescale 1ns / 1ps

package afc_pkg;

  localparam int SlotCount = 16;
  localparam int SlotW     = 4;
  localparam int AddrW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int LenW      = 3;
  localparam int ByteCount = 7;

  localparam logic [7:0] CrcPoly  = 8'h1D;
  localparam logic [7:0] CrcInit  = 8'hFF;
  localparam logic [7:0] WrapMark = 8'h0F;
  localparam logic [7:0] TopBit   = 8'h80;
  localparam logic [7:0] CntReset = 8'hFF;

  typedef enum logic {
    CMD_SEND   = 1'b0,
    CMD_PRESET = 1'b1
  } afc_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CRC,
    ST_DONE
  } afc_state_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic init;
    logic step;
  } crc_ctl_t;

  // One CRC-8 byte update, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((r & TopBit) != 8'h00) begin
        r = {r[6:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/afc_cnt_mem.sv =====
// Alive-counter store: one synchronous RAM with a registered read port.
// Per-entry valid bits make unwritten entries read as the reset value.
// Depends on afc_pkg.
`timescale 1ns / 1ps

module afc_cnt_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [afc_pkg::AddrW-1:0] rd_addr_i,
  input  afc_pkg::mem_wr_t          wr_i,
  output logic [7:0]                rd_data_o
);

  logic [7:0]                   mem_q [afc_pkg::SlotCount];
  logic [afc_pkg::SlotCount-1:0] vld_q;
  logic [7:0]                   rd_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : afc_pkg::CntReset;

endmodule

// ===== sv/afc_crc8.sv =====
// Byte-serial CRC-8 unit: one byte folded into the remainder per cycle while step is high.
// Depends on afc_pkg.
`timescale 1ns / 1ps

module afc_crc8 (
  input  logic              clk_i,
  input  afc_pkg::crc_ctl_t ctl_i,
  input  logic [7:0]        byte_i,
  output logic [7:0]        crc_o
);

  logic [7:0] crc_q;
  logic [7:0] crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.init) begin
      crc_d = afc_pkg::CrcInit;
    end else if (ctl_i.step) begin
      crc_d = afc_pkg::crc8_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign crc_o = crc_q;

endmodule

// ===== sv/alive_counter_crc8_frame_protect.sv =====
// Top level of the alive-counter / CRC-8 frame protection block.
// Instantiates afc_cnt_mem (counter RAM) and afc_crc8 (byte-serial CRC); uses afc_pkg.
//
//  channel   | handshake            | fields
//  ----------+----------------------+------------------------------------------------
//  command   | start, busy          | cmd_i slot_i crc_xor_i crc_len_i preset_value_i
//            |                      | payload_b2_i .. payload_b7_i
//  result    | done_o (1-cycle)     | slot_out_o counter_out_o crc_out_o
//
// An item is taken when start is high and busy is low. A send item passes
// from acceptance through the RAM read state, then the byte-serial CRC loop
// with one step per CRC byte, then the result state, and back to idle.
// Presets, sends with zero CRC length and out-of-range slots skip the loop.
// Reset clears the control state and the counter valid bits, so every slot
// reads as 0xFF at once; there is no clearing pass. The result strobe lasts
// exactly one cycle and cannot be held off; busy stays high until it is gone.
`timescale 1ns / 1ps

module alive_counter_crc8_frame_protect (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd_i,
  input  logic [afc_pkg::SlotW-1:0] slot_i,
  input  logic [7:0]                crc_xor_i,
  input  logic [afc_pkg::LenW-1:0]  crc_len_i,
  input  logic [7:0]                preset_value_i,
  input  logic [7:0]                payload_b2_i,
  input  logic [7:0]                payload_b3_i,
  input  logic [7:0]                payload_b4_i,
  input  logic [7:0]                payload_b5_i,
  input  logic [7:0]                payload_b6_i,
  input  logic [7:0]                payload_b7_i,
  output logic                      done_o,
  output logic [afc_pkg::SlotW-1:0] slot_out_o,
  output logic [7:0]                counter_out_o,
  output logic [7:0]                crc_out_o
);

  afc_pkg::afc_state_e state_q, state_d;

  // Item registers, captured on acceptance.
  afc_pkg::afc_cmd_e          cmd_q;
  logic [afc_pkg::SlotW-1:0]  slot_q;
  logic                       in_range_q;
  logic [7:0]                 xor_q;
  logic [afc_pkg::LenW-1:0]   rem_q, rem_d;
  logic [7:0]                 preset_q;
  logic [7:0]                 bytes_q [afc_pkg::ByteCount];
  logic [7:0]                 cnt_out_q;

  logic                       accept;
  logic                       rd_en;
  logic [7:0]                 rd_data;
  logic [7:0]                 cnt_inc;
  logic [7:0]                 cnt_new;
  afc_pkg::mem_wr_t           mem_wr;
  afc_pkg::crc_ctl_t          crc_ctl;
  logic [7:0]                 crc;

  assign accept = start && !busy;
  assign rd_en  = accept;

  // Advance the counter; the wrap mark collapses to zero.
  assign cnt_inc = rd_data + 8'd1;
  assign cnt_new = (cnt_inc == afc_pkg::WrapMark) ? 8'h00 : cnt_inc;

  afc_cnt_mem u_cnt_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (afc_pkg::AddrW'(slot_i)),
    .wr_i      (mem_wr),
    .rd_data_o (rd_data)
  );

  afc_crc8 u_crc8 (
    .clk_i  (clk_i),
    .ctl_i  (crc_ctl),
    .byte_i (bytes_q[0]),
    .crc_o  (crc)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      afc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = afc_pkg::ST_READ;
        end
      end
      afc_pkg::ST_READ: begin
        if (in_range_q && (cmd_q == afc_pkg::CMD_SEND) && (rem_q != '0)) begin
          state_d = afc_pkg::ST_CRC;
        end else begin
          state_d = afc_pkg::ST_DONE;
        end
      end
      afc_pkg::ST_CRC: begin
        if (rem_q == afc_pkg::LenW'(1)) begin
          state_d = afc_pkg::ST_DONE;
        end
      end
      afc_pkg::ST_DONE: begin
        state_d = afc_pkg::ST_IDLE;
      end
      default: state_d = afc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    busy         = 1'b1;
    done_o       = 1'b0;
    mem_wr.en    = 1'b0;
    mem_wr.addr  = afc_pkg::AddrW'(slot_q);
    mem_wr.data  = (cmd_q == afc_pkg::CMD_PRESET) ? preset_q : cnt_new;
    crc_ctl.init = 1'b0;
    crc_ctl.step = 1'b0;
    rem_d        = rem_q;
    unique case (state_q)
      afc_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      afc_pkg::ST_READ: begin
        // Write back the advanced or preset counter; out-of-range slots leave the RAM alone.
        mem_wr.en    = in_range_q;
        crc_ctl.init = 1'b1;
      end
      afc_pkg::ST_CRC: begin
        crc_ctl.step = 1'b1;
        rem_d        = rem_q - afc_pkg::LenW'(1);
      end
      afc_pkg::ST_DONE: begin
        done_o = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers: capture on accept, load the counter byte after the read,
  // advance the byte line one step per CRC cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= afc_pkg::afc_cmd_e'(cmd_i);
      slot_q     <= slot_i;
      in_range_q <= (int'(slot_i) < afc_pkg::SlotCount);
      xor_q      <= crc_xor_i;
      rem_q      <= crc_len_i;
      preset_q   <= preset_value_i;
      bytes_q[1] <= payload_b2_i;
      bytes_q[2] <= payload_b3_i;
      bytes_q[3] <= payload_b4_i;
      bytes_q[4] <= payload_b5_i;
      bytes_q[5] <= payload_b6_i;
      bytes_q[6] <= payload_b7_i;
    end else begin
      rem_q <= rem_d;
      if (state_q == afc_pkg::ST_READ) begin
        bytes_q[0] <= cnt_new;
        cnt_out_q  <= in_range_q ? mem_wr.data : 8'h00;
      end else if (crc_ctl.step) begin
        for (int k = 0; k < afc_pkg::ByteCount - 1; k++) begin
          bytes_q[k] <= bytes_q[k+1];
        end
      end
    end
  end

  assign slot_out_o    = slot_q;
  assign counter_out_o = cnt_out_q;
  assign crc_out_o     = (in_range_q && (cmd_q == afc_pkg::CMD_SEND)) ? (crc ^ xor_q) : 8'h00;

  // Accepting an item raises busy in the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // The result strobe lasts a single cycle and frees the block.
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  // The CRC loop only runs with bytes left to fold.
  a_crc_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == afc_pkg::ST_CRC) |-> (rem_q != '0))
    else $error("CRC step with no bytes left");

  // A result follows a RAM read phase or the CRC loop, never an idle cycle.
  a_done_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == afc_pkg::ST_READ || $past(state_q) == afc_pkg::ST_CRC))
    else $error("result without preceding work");

  // A preset result carries a zero CRC byte.
  a_preset_crc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (cmd_q == afc_pkg::CMD_PRESET)) |-> (crc_out_o == 8'h00))
    else $error("preset result with nonzero CRC");

endmodule

// ===== bench/alive_counter_crc8_frame_protect_test.sv =====
// Self-checking bench for alive_counter_crc8_frame_protect: directed and random items.
// Predicts each result with its own counter store and CRC-8 and compares every strobe.
// Depends on afc_pkg for the command enum and the slot count.
`timescale 1ns / 1ps

module alive_counter_crc8_frame_protect_test;

  // CRC-8 parameters of the protected frames
  localparam logic [7:0] FramePoly  = 8'h1D;
  localparam logic [7:0] FrameSeed  = 8'hFF;
  localparam logic [7:0] CntWrapHit = 8'h0F;
  localparam logic [7:0] CntPowerUp = 8'hFF;
  localparam int         StallLimit = 500;  // cycles with no item and no result
  localparam int         DrainCycles = 12;  // settle time after the last owed result

  typedef struct packed {
    afc_pkg::afc_cmd_e cmd;
    logic [3:0]        slot;
    logic [7:0]        crc_xor;
    logic [2:0]        crc_len;
    logic [7:0]        preset_value;
    logic [5:0][7:0]   payload;  // [0] is frame byte 2 .. [5] is frame byte 7
  } frame_item_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [7:0] counter;
    logic [7:0] crc;
  } frame_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       cmd_i;
  logic [3:0] slot_i;
  logic [7:0] crc_xor_i;
  logic [2:0] crc_len_i;
  logic [7:0] preset_value_i;
  logic [7:0] payload_b2_i;
  logic [7:0] payload_b3_i;
  logic [7:0] payload_b4_i;
  logic [7:0] payload_b5_i;
  logic [7:0] payload_b6_i;
  logic [7:0] payload_b7_i;
  logic       done_o;
  logic [3:0] slot_out_o;
  logic [7:0] counter_out_o;
  logic [7:0] crc_out_o;

  alive_counter_crc8_frame_protect dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .slot_i         (slot_i),
    .crc_xor_i      (crc_xor_i),
    .crc_len_i      (crc_len_i),
    .preset_value_i (preset_value_i),
    .payload_b2_i   (payload_b2_i),
    .payload_b3_i   (payload_b3_i),
    .payload_b4_i   (payload_b4_i),
    .payload_b5_i   (payload_b5_i),
    .payload_b6_i   (payload_b6_i),
    .payload_b7_i   (payload_b7_i),
    .done_o         (done_o),
    .slot_out_o     (slot_out_o),
    .counter_out_o  (counter_out_o),
    .crc_out_o      (crc_out_o)
  );

  // Mirror of the block's per-slot alive counters and the results still owed
  logic [7:0]    alive_mirror [afc_pkg::SlotCount];
  frame_result_t pending_frames [$];

  int  error_count;
  int  item_count;
  int  preset_count;
  int  wrap_count;
  int  checked_count;
  int  stall_cycles;
  bit  gaps_on;
  int  gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // One MSB-first CRC-8 byte update, no reflection.
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ FramePoly) : {r[6:0], 1'b0};
    return r;
  endfunction

  // Advance the mirror for one item and return the result the block owes.
  function automatic frame_result_t protect_frame(input frame_item_t it);
    frame_result_t res;
    logic [6:0][7:0] frame;
    logic [7:0]      cnt;
    logic [7:0]      crc;
    res.slot    = it.slot;
    res.counter = 8'h00;
    res.crc     = 8'h00;
    // Out-of-range slots leave the store alone and report zeros
    if (int'(it.slot) >= afc_pkg::SlotCount) return res;
    if (it.cmd == afc_pkg::CMD_PRESET) begin
      alive_mirror[it.slot] = it.preset_value;
      res.counter = it.preset_value;
      return res;
    end
    cnt = alive_mirror[it.slot] + 8'd1;
    // Only the value 0x0F is folded back to zero; 0xFF rolls over by itself
    if (cnt == CntWrapHit) begin
      cnt = 8'h00;
      wrap_count++;
    end
    alive_mirror[it.slot] = cnt;
    frame = {it.payload, cnt};
    crc = FrameSeed;
    for (int i = 0; i < int'(it.crc_len); i++) crc = crc8_fold(crc, frame[i]);
    res.counter = cnt;
    res.crc     = crc ^ it.crc_xor;
    return res;
  endfunction

  function automatic frame_item_t random_frame(input int preset_pct, input int slot_hi);
    frame_item_t it;
    it.cmd          = ($urandom_range(0, 99) < preset_pct) ? afc_pkg::CMD_PRESET
                                                           : afc_pkg::CMD_SEND;
    it.slot         = 4'($urandom_range(0, slot_hi));
    it.crc_xor      = 8'($urandom);
    it.crc_len      = 3'($urandom);
    it.payload      = {16'($urandom), 32'($urandom)};
    // Bias presets toward values just below the wrap points
    case ($urandom_range(0, 3))
      0: it.preset_value = 8'h0E;
      1: it.preset_value = 8'hFE;
      default: it.preset_value = 8'($urandom);
    endcase
    return it;
  endfunction

  function automatic frame_item_t make_frame(input afc_pkg::afc_cmd_e cmd,
                                             input logic [3:0] slot,
                                             input logic [7:0] xr, input logic [2:0] len,
                                             input logic [7:0] pv, input logic [7:0] fill);
    frame_item_t it;
    it.cmd          = cmd;
    it.slot         = slot;
    it.crc_xor      = xr;
    it.crc_len      = len;
    it.preset_value = pv;
    it.payload      = {6{fill}};
    return it;
  endfunction

  // Drive one item and hold it until the block takes it. Start stays high on
  // return so that a following item goes back to back.
  task automatic issue_frame(input frame_item_t it);
    start          <= 1'b1;
    cmd_i          <= it.cmd;
    slot_i         <= it.slot;
    crc_xor_i      <= it.crc_xor;
    crc_len_i      <= it.crc_len;
    preset_value_i <= it.preset_value;
    payload_b2_i   <= it.payload[0];
    payload_b3_i   <= it.payload[1];
    payload_b4_i   <= it.payload[2];
    payload_b5_i   <= it.payload[3];
    payload_b6_i   <= it.payload[4];
    payload_b7_i   <= it.payload[5];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_frames.push_back(protect_frame(it));
    item_count++;
    if (it.cmd == afc_pkg::CMD_PRESET) preset_count++;
  endtask

  // Drop start for a random burst, so gaps land on every phase of a send.
  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Every slot starts at 0xFF, so the first send must roll it over to zero.
  task automatic test_power_up_counters();
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd0, 8'h00, 3'd0, 8'h00, 8'h00));
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd15, 8'hFF, 3'd7, 8'hFF, 8'hFF));
    sender_gap();
  endtask

  // Field extremes, every CRC length, presets and both wrap points.
  task automatic test_directed_frames();
    // Preset ignores CRC fields and payload, even at their maxima
    issue_frame(make_frame(afc_pkg::CMD_PRESET, 4'd3, 8'hFF, 3'd7, 8'h0E, 8'hFF));
    // 0x0E advances to 0x0F, which is forced to zero
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd3, 8'h5A, 3'd1, 8'h00, 8'h00));
    issue_frame(make_frame(afc_pkg::CMD_PRESET, 4'd5, 8'h00, 3'd0, 8'hFE, 8'h00));
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd5, 8'h00, 3'd2, 8'hFF, 8'hAA));
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd5, 8'hA5, 3'd3, 8'h00, 8'h55));
    // Start-up value used by the message file
    issue_frame(make_frame(afc_pkg::CMD_PRESET, 4'd7, 8'h00, 3'd0, 8'h3E, 8'h00));
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd7, 8'h00, 3'd1, 8'h00, 8'h00));
    issue_frame(make_frame(afc_pkg::CMD_PRESET, 4'd0, 8'hFF, 3'd7, 8'h00, 8'hFF));
    issue_frame(make_frame(afc_pkg::CMD_PRESET, 4'd15, 8'h00, 3'd0, 8'hFF, 8'h00));
    sender_gap();
    for (int len = 0; len < 8; len++) begin
      issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd9, 8'(len * 37), 3'(len), 8'h00,
                             (len % 2 == 0) ? 8'hAA : 8'h55));
    end
    // Zero length gives the seed XOR the mask; counter still advances
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd9, 8'hFF, 3'd0, 8'h00, 8'hFF));
    issue_frame(make_frame(afc_pkg::CMD_SEND, 4'd15, 8'h00, 3'd7, 8'h00, 8'h00));
    sender_gap();
  endtask

  // Random mix, changing idle density every few dozen items, sometimes
  // crowding traffic onto a few slots so their counters run far.
  task automatic test_random_traffic(input int count);
    int slot_hi;
    int preset_pct;
    slot_hi    = afc_pkg::SlotCount - 1;
    preset_pct = 15;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
        slot_hi    = ($urandom_range(0, 2) == 0) ? 1 : afc_pkg::SlotCount - 1;
        preset_pct = $urandom_range(3, 25);
      end
      issue_frame(random_frame(preset_pct, slot_hi));
      sender_gap();
    end
  endtask

  // Back-to-back stream with no gaps at all.
  task automatic test_streaming(input int count);
    gaps_on = 1'b0;
    for (int n = 0; n < count; n++) issue_frame(random_frame(10, afc_pkg::SlotCount - 1));
    start <= 1'b0;
  endtask

  // Compare every strobed result against the oldest owed one.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && done_o) begin
      if (pending_frames.size() == 0) begin
        $error("result with nothing owed: slot_out %0h counter_out %0h crc_out %0h",
               slot_out_o, counter_out_o, crc_out_o);
        error_count++;
      end else begin
        want = pending_frames.pop_front();
        checked_count++;
        if (slot_out_o !== want.slot) begin
          $error("slot_out: expected %0h, got %0h", want.slot, slot_out_o);
          error_count++;
        end
        if (counter_out_o !== want.counter) begin
          $error("counter_out: expected %0h, got %0h", want.counter, counter_out_o);
          error_count++;
        end
        if (crc_out_o !== want.crc) begin
          $error("crc_out: expected %0h, got %0h", want.crc, crc_out_o);
          error_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("timeout after %0d quiet cycles, %0d results owed",
               stall_cycles, pending_frames.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    error_count    = 0;
    item_count     = 0;
    preset_count   = 0;
    wrap_count     = 0;
    checked_count  = 0;
    stall_cycles   = 0;
    gaps_on        = 1'b1;
    gap_pct        = 40;
    for (int s = 0; s < afc_pkg::SlotCount; s++) alive_mirror[s] = CntPowerUp;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    cmd_i          <= 1'b0;
    slot_i         <= '0;
    crc_xor_i      <= '0;
    crc_len_i      <= '0;
    preset_value_i <= '0;
    payload_b2_i   <= '0;
    payload_b3_i   <= '0;
    payload_b4_i   <= '0;
    payload_b5_i   <= '0;
    payload_b6_i   <= '0;
    payload_b7_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up_counters();
    test_directed_frames();
    test_random_traffic(690);
    test_streaming(90);

    // Hold until every owed result is in, then let the block settle
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d items (%0d presets, %0d counter folds at 0x0F) over %0d slots;",
             item_count, preset_count, wrap_count, afc_pkg::SlotCount);
    $display("%0d results checked field by field, %0d failures.", checked_count, error_count);
    if (error_count == 0 && pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/afc_pkg.sv
sv/afc_cnt_mem.sv
sv/afc_crc8.sv
sv/alive_counter_crc8_frame_protect.sv
bench/alive_counter_crc8_frame_protect_test.sv
